// ----- rtl/core/srsa_pkg.sv -----
// srsa_pkg: shared codes, widths and control types of the sparse row scaled add
// no dependencies
`default_nettype none
package srsa_pkg;

  localparam int VALUE_W = 32;
  localparam int THR_W   = 31;
  localparam int CFG_IW  = 2;

  localparam logic [1:0] CMD_A   = 2'd0;
  localparam logic [1:0] CMD_B   = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;

  localparam logic [CFG_IW-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IW-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_THR   = 2'd2;

  // access request to the row table
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_new;
  } srsa_tbl_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/srsa_in_if.sv -----
// srsa_in_if: input element channel, valid/ready with command, column and value
// depends on nothing
`default_nettype none
interface srsa_in_if #(parameter int COLUMN_BITS = 16) ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [COLUMN_BITS-1:0]  column;
  logic signed [31:0]      value;
  modport source (output valid, command, column, value, input ready);
  modport sink (input valid, command, column, value, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/srsa_out_if.sv -----
// srsa_out_if: result channel, valid/ready with one row entry per transfer
// depends on nothing
`default_nettype none
interface srsa_out_if #(parameter int COLUMN_BITS = 16) ();
  logic                    valid;
  logic                    ready;
  logic [COLUMN_BITS-1:0]  out_column;
  logic signed [31:0]      out_value;
  logic                    entry_valid;
  logic                    row_last;
  logic                    overflow;
  modport source (output valid, out_column, out_value, entry_valid, row_last, overflow,
                  input ready);
  modport sink (input valid, out_column, out_value, entry_valid, row_last, overflow,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/srsa_scaler.sv -----
// srsa_scaler: two-stage Q16.16 multiply, floor shift and saturation
// depends on srsa_pkg
`default_nettype none
module srsa_scaler
  import srsa_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [VALUE_W-1:0] a,
  input  wire logic signed [VALUE_W-1:0] b,
  output logic signed [VALUE_W-1:0]      res
);

  logic signed [2*VALUE_W-1:0] prod;
  logic signed [2*VALUE_W-1:0] shifted;

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod >>> 16;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (shifted > 64'sh7fffffff) begin
      res <= 32'sh7fffffff;
    end else if (shifted < -64'sh80000000) begin
      res <= -32'sh80000000;
    end else begin
      res <= shifted[VALUE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/srsa_row_table.sv -----
// srsa_row_table: column tags in flops for match, values in a synchronous memory
// depends on srsa_pkg
`default_nettype none
module srsa_row_table
  import srsa_pkg::*;
#(
  parameter int ROW_CAPACITY = 32,
  parameter int COLUMN_BITS  = 16,
  parameter int IW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1,
  parameter int CW = $clog2(ROW_CAPACITY + 1)
)(
  input  wire logic                      clk,
  input  wire srsa_tbl_ctl_t             ctl,
  input  wire logic [IW-1:0]             addr,
  input  wire logic [CW-1:0]             count,
  input  wire logic [COLUMN_BITS-1:0]    match_col,
  input  wire logic signed [VALUE_W-1:0] wr_val,
  output logic                           hit,
  output logic [IW-1:0]                  hit_idx,
  output logic [COLUMN_BITS-1:0]         rd_col,
  output logic signed [VALUE_W-1:0]      rd_val
);

  logic [COLUMN_BITS-1:0]    cols [ROW_CAPACITY];
  logic signed [VALUE_W-1:0] vals [ROW_CAPACITY];

  // stored columns are unique, so at most one entry matches
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      if (!hit && (CW'(i) < count) && (cols[i] == match_col)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      vals[addr] <= wr_val;
      if (ctl.wr_new) begin
        cols[addr] <= match_col;
      end
    end
    if (ctl.rd_en) begin
      rd_val <= vals[addr];
      rd_col <= cols[addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sparse_row_scaled_add.sv -----
// sparse_row_scaled_add: builds one sparse row of alpha*A + beta*B and streams it out
// depends on srsa_pkg, srsa_in_if, srsa_out_if, srsa_scaler, srsa_row_table
//
// usage: elements carries commands A element, B element and end of row. each
// A or B element is scaled by alpha_scale or beta_scale, then added into the
// stored entry of the same column or appended as a new entry. after its
// transfer an element passes through multiply, shift/saturate with the column
// match and value memory read, then the saturating add and write back, before
// the next ready. end of row walks the value memory with a read and a check
// state per stored entry, then a closing state, and sends every entry with
// |value| > drop_threshold on results in storage order; row_last marks the
// final one. a row with no surviving entry sends one result with entry_valid
// low. overflow is set on each result when the full table dropped elements.
// results has one output register; when the receiver stalls the walk waits
// and no new element is taken until the row is done. command 3 is dropped.
// reset (rst, synchronous) empties the table and restores the register
// defaults; no clearing pass is needed. configuration is written on cfg_write;
// the user must write it only while the block is idle; the block does not enforce this.
`default_nettype none
module sparse_row_scaled_add
  import srsa_pkg::*;
#(
  parameter int ROW_CAPACITY = 32,
  parameter int COLUMN_BITS  = 16
)(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [VALUE_W-1:0] cfg_data,
  srsa_in_if.sink                 elements,
  srsa_out_if.source              results
);

  localparam int IW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int CW = $clog2(ROW_CAPACITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SCL, S_UPD, S_RD, S_CHK, S_FIN} state_t;

  state_t state;

  logic signed [VALUE_W-1:0] alpha_scale, beta_scale;
  logic [THR_W-1:0]          drop_threshold;

  logic [COLUMN_BITS-1:0]    col_q;
  logic signed [VALUE_W-1:0] val_q, scl_q;
  logic [CW-1:0]             count;
  logic                      ovf;
  logic [IW-1:0]             idx;

  logic                      pend_v;
  logic [COLUMN_BITS-1:0]    pend_col;
  logic signed [VALUE_W-1:0] pend_val;

  srsa_tbl_ctl_t             ctl;
  logic [IW-1:0]             addr;
  logic                      hit;
  logic [IW-1:0]             hit_idx;
  logic [COLUMN_BITS-1:0]    rd_col;
  logic signed [VALUE_W-1:0] rd_val, scaled, wr_val;
  logic signed [VALUE_W:0]   sum;
  logic [VALUE_W:0]          mag;
  logic                      keep, out_free, room, idx_last;
  logic                      push;

  assign elements.ready = (state == S_IDLE);
  assign out_free = !results.valid || results.ready;
  assign room     = count < CW'(ROW_CAPACITY);
  assign idx_last = (CW'(idx) + CW'(1)) == count;

  assign sum = {rd_val[VALUE_W-1], rd_val} + {scaled[VALUE_W-1], scaled};
  assign mag = rd_val[VALUE_W-1] ? -{1'b1, rd_val} : {1'b0, rd_val};
  assign keep = mag > {2'b00, drop_threshold};

  // a result is loaded into the output register this cycle
  assign push = out_free && ((state == S_FIN) || (state == S_CHK && keep && pend_v));

  srsa_scaler u_scaler (
    .clk (clk),
    .a   (val_q),
    .b   (scl_q),
    .res (scaled)
  );

  always_comb begin
    ctl    = '0;
    addr   = hit_idx;
    wr_val = scaled;
    unique case (state)
      S_SCL: begin
        ctl.rd_en = hit;
      end
      S_UPD: begin
        if (hit) begin
          ctl.wr_en = 1'b1;
          if (sum > 33'sh07fffffff) begin
            wr_val = 32'sh7fffffff;
          end else if (sum < -33'sh080000000) begin
            wr_val = -32'sh80000000;
          end else begin
            wr_val = sum[VALUE_W-1:0];
          end
        end else if (room) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_new = 1'b1;
          addr       = count[IW-1:0];
        end
      end
      S_RD: begin
        ctl.rd_en = 1'b1;
        addr      = idx;
      end
      default: begin
      end
    endcase
  end

  srsa_row_table #(
    .ROW_CAPACITY (ROW_CAPACITY),
    .COLUMN_BITS  (COLUMN_BITS),
    .IW           (IW),
    .CW           (CW)
  ) u_table (
    .clk       (clk),
    .ctl       (ctl),
    .addr      (addr),
    .count     (count),
    .match_col (col_q),
    .wr_val    (wr_val),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .rd_col    (rd_col),
    .rd_val    (rd_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_scale    <= 32'sh00010000;
      beta_scale     <= 32'sh00010000;
      drop_threshold <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALPHA: alpha_scale    <= cfg_data;
        REG_BETA:  beta_scale     <= cfg_data;
        REG_THR:   drop_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      ovf           <= 1'b0;
      pend_v        <= 1'b0;
      idx           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (push) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (elements.valid) begin
            col_q <= elements.column;
            val_q <= elements.value;
            scl_q <= (elements.command == CMD_A) ? alpha_scale : beta_scale;
            idx   <= '0;
            if (elements.command == CMD_A || elements.command == CMD_B) begin
              state <= S_MUL;
            end else if (elements.command == CMD_END) begin
              state <= (count == '0) ? S_FIN : S_RD;
            end
          end
        end
        S_MUL: state <= S_SCL;
        S_SCL: state <= S_UPD;
        S_UPD: begin
          if (!hit) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          // a kept entry flushes the previous one, which is then known not last
          if (!(keep && pend_v && !out_free)) begin
            if (keep) begin
              if (pend_v) begin
                results.out_column  <= pend_col;
                results.out_value   <= pend_val;
                results.entry_valid <= 1'b1;
                results.row_last    <= 1'b0;
                results.overflow    <= ovf;
              end
              pend_v   <= 1'b1;
              pend_col <= rd_col;
              pend_val <= rd_val;
            end
            if (idx_last) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            results.out_column  <= pend_v ? pend_col : '0;
            results.out_value   <= pend_v ? pend_val : '0;
            results.entry_valid <= pend_v;
            results.row_last    <= 1'b1;
            results.overflow    <= ovf;
            pend_v <= 1'b0;
            count  <= '0;
            ovf    <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ROW_CAPACITY)) else $error("entry count above capacity");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> count == CW'(ROW_CAPACITY)) else $error("overflow with room left");
  a_row_closed: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (count == '0 && !pend_v))
    else $error("row not cleared after close");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.entry_valid) |-> results.row_last)
    else $error("empty marker not last");
`endif

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: self-checking bench for sparse_row_scaled_add, directed table then random rows
// depends on srsa_pkg, srsa_in_if, srsa_out_if and the sparse_row_scaled_add rtl
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import srsa_pkg::*;

  localparam int CAPACITY = 32;
  localparam int COL_W = 16;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [COL_W-1:0]   column;
    logic signed [31:0] value;
    logic               entry_valid;
    logic               row_last;
    logic               overflow;
  } row_entry_t;

  typedef struct {
    logic [1:0]         command;
    logic [COL_W-1:0]   column;
    logic signed [31:0] value;
    bit                 typed_in;
    row_entry_t         result;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IW-1:0] cfg_index;
  logic [VALUE_W-1:0] cfg_data;

  srsa_in_if #(.COLUMN_BITS(COL_W)) elem_ch ();
  srsa_out_if #(.COLUMN_BITS(COL_W)) res_ch ();

  sparse_row_scaled_add #(.ROW_CAPACITY(CAPACITY), .COLUMN_BITS(COL_W)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .elements(elem_ch),
    .results(res_ch)
  );

  // predictor copy of the row table and registers
  logic [COL_W-1:0]   tbl_col [CAPACITY];
  logic signed [31:0] tbl_val [CAPACITY];
  int                 tbl_count;
  bit                 tbl_ovf;
  logic signed [31:0] alpha_q;
  logic signed [31:0] beta_q;
  logic [30:0]        thr_q;

  row_entry_t expected_rows[$];
  int mismatches;
  int orphans;
  int items_sent;
  int rows_ended;
  int results_seen;
  int idle_cycles;
  int tx_idle_pct;
  int rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scale_q16(logic signed [31:0] v, logic signed [31:0] s);
    longint prod;
    prod = longint'(v) * longint'(s);
    return sat32(prod >>> 16);
  endfunction

  function automatic bit survives(logic signed [31:0] v);
    longint mag;
    mag = longint'(v);
    if (mag < 0) mag = -mag;
    return mag > longint'(thr_q);
  endfunction

  function automatic void merge_entry(logic [COL_W-1:0] col, logic signed [31:0] val);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_col[i] == col) begin
        tbl_val[i] = sat32(longint'(tbl_val[i]) + longint'(val));
        return;
      end
    end
    if (tbl_count >= CAPACITY) begin
      tbl_ovf = 1'b1;
      return;
    end
    tbl_col[tbl_count] = col;
    tbl_val[tbl_count] = val;
    tbl_count++;
  endfunction

  // applies one accepted element; at end of row returns the emitted entries
  function automatic void predict_row(logic [1:0] cmd, logic [COL_W-1:0] col,
                                      logic signed [31:0] val, ref row_entry_t emitted[$]);
    int last;
    row_entry_t e;
    emitted.delete();
    last = -1;
    case (cmd)
      CMD_A: merge_entry(col, scale_q16(val, alpha_q));
      CMD_B: merge_entry(col, scale_q16(val, beta_q));
      CMD_END: begin
        for (int i = 0; i < tbl_count; i++)
          if (survives(tbl_val[i])) last = i;
        if (last < 0) begin
          e = '{column: '0, value: '0, entry_valid: 1'b0, row_last: 1'b1, overflow: tbl_ovf};
          emitted.push_back(e);
        end else begin
          for (int i = 0; i <= last; i++) begin
            if (!survives(tbl_val[i])) continue;
            e = '{column: tbl_col[i], value: tbl_val[i], entry_valid: 1'b1,
                  row_last: (i == last), overflow: tbl_ovf};
            emitted.push_back(e);
          end
        end
        tbl_count = 0;
        tbl_ovf = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // write enable stays high across back-to-back writes; set_scales drops it
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ALPHA: alpha_q = data;
      REG_BETA:  beta_q = data;
      REG_THR:   thr_q = data[30:0];
      default: ;
    endcase
  endtask

  task automatic set_scales(logic [31:0] a, logic [31:0] b, logic [31:0] t);
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, b);
    write_reg(REG_THR, t);
    cfg_write <= 1'b0;
  endtask

  // wait for every pending result, then for an element still in flight
  task automatic wait_drained();
    elem_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one transfer on the element channel; typed_in replaces the predicted results
  task automatic send_element(logic [1:0] cmd, logic [COL_W-1:0] col, logic [31:0] val,
                              bit typed_in = 1'b0, row_entry_t typed = '{default: '0});
    row_entry_t emitted[$];
    while ($urandom_range(99) < tx_idle_pct) begin
      elem_ch.valid <= 1'b0;
      @(posedge clk);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.command <= cmd;
    elem_ch.column <= col;
    elem_ch.value <= val;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    predict_row(cmd, col, val, emitted);
    if (typed_in) expected_rows.push_back(typed);
    else foreach (emitted[i]) expected_rows.push_back(emitted[i]);
    if (cmd != CMD_NOP) items_sent++;
    if (cmd == CMD_END) rows_ended++;
  endtask

  task automatic fill_past_capacity();
    int base;
    base = $urandom_range(0, 1000);
    for (int i = 0; i < CAPACITY + 3; i++)
      send_element(($urandom_range(1) != 0) ? CMD_A : CMD_B, COL_W'(base + i * 7),
                   $urandom_range(32'h0003ffff, 32'h00010000));
    // a repeated column still merges once the table is full
    send_element(CMD_B, COL_W'(base), 32'h00020000);
    send_element(CMD_END, '0, '0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0003ffff) - 32'h00020000;
      2: return ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed rows; some carry stray commands or run on into the next row
  task automatic random_row();
    int len;
    bit wide;
    logic [1:0] cmd;
    len = $urandom_range(1, 12);
    wide = ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(11) == 0) cmd = CMD_NOP;
      else cmd = ($urandom_range(1) != 0) ? CMD_A : CMD_B;
      send_element(cmd, wide ? COL_W'($urandom) : COL_W'($urandom_range(15)), pick_value());
    end
    if ($urandom_range(7) != 0) send_element(CMD_END, COL_W'($urandom), $urandom);
  endtask

  stim_row_t directed_rows [15] = '{
    '{CMD_END, 16'h0000, 32'h00000000, 1'b1, '{16'h0000, 32'h00000000, 1'b0, 1'b1, 1'b0}},
    '{CMD_A,   16'h0000, 32'h7fffffff, 1'b0, '{default: '0}},
    '{CMD_A,   16'hffff, 32'h80000000, 1'b0, '{default: '0}},
    '{CMD_B,   16'h0000, 32'h00000001, 1'b0, '{default: '0}},
    '{CMD_B,   16'hffff, 32'hffffffff, 1'b0, '{default: '0}},
    '{CMD_A,   16'h5555, 32'h00010000, 1'b0, '{default: '0}},
    '{CMD_B,   16'haaaa, 32'hfffe8000, 1'b0, '{default: '0}},
    '{CMD_A,   16'h5555, 32'hffff0000, 1'b0, '{default: '0}},
    '{CMD_NOP, 16'h1234, 32'h7fffffff, 1'b0, '{default: '0}},
    '{CMD_END, 16'hffff, 32'hffffffff, 1'b0, '{default: '0}},
    '{CMD_A,   16'h0003, 32'h00000000, 1'b0, '{default: '0}},
    '{CMD_B,   16'h0003, 32'h00000000, 1'b0, '{default: '0}},
    '{CMD_END, 16'h0000, 32'h00000000, 1'b1, '{16'h0000, 32'h00000000, 1'b0, 1'b1, 1'b0}},
    '{CMD_A,   16'h0009, 32'h80000000, 1'b0, '{default: '0}},
    '{CMD_END, 16'h0000, 32'h00000000, 1'b1, '{16'h0009, 32'h80000000, 1'b1, 1'b1, 1'b0}}
  };

  // result checker
  always @(posedge clk) begin
    row_entry_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_rows.size() == 0) begin
        orphans++;
        if (orphans + mismatches <= 10)
          $display("unexpected result: col %h value %h valid %b last %b ovf %b",
                   res_ch.out_column, res_ch.out_value, res_ch.entry_valid,
                   res_ch.row_last, res_ch.overflow);
      end else begin
        want = expected_rows.pop_front();
        if (res_ch.out_column !== want.column || res_ch.out_value !== want.value ||
            res_ch.entry_valid !== want.entry_valid || res_ch.row_last !== want.row_last ||
            res_ch.overflow !== want.overflow) begin
          mismatches++;
          if (orphans + mismatches <= 10)
            $display("mismatch: expected col %h value %h valid %b last %b ovf %b, got col %h value %h valid %b last %b ovf %b",
                     want.column, want.value, want.entry_valid, want.row_last, want.overflow,
                     res_ch.out_column, res_ch.out_value, res_ch.entry_valid,
                     res_ch.row_last, res_ch.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("sparse_row_scaled_add test failed");
        $finish;
      end
    end
  end

  initial begin
    int phase_start;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    elem_ch.valid = 1'b0;
    elem_ch.command = CMD_NOP;
    elem_ch.column = '0;
    elem_ch.value = '0;
    res_ch.ready = 1'b0;
    idle_cycles = 0;
    mismatches = 0;
    orphans = 0;
    items_sent = 0;
    rows_ended = 0;
    results_seen = 0;
    tbl_count = 0;
    tbl_ovf = 1'b0;
    alpha_q = 32'h00010000;
    beta_q = 32'h00010000;
    thr_q = '0;
    tx_idle_pct = 26;
    rx_idle_pct = 45;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with the reset defaults
    foreach (directed_rows[i])
      send_element(directed_rows[i].command, directed_rows[i].column, directed_rows[i].value,
                   directed_rows[i].typed_in, directed_rows[i].result);
    fill_past_capacity();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_scales(32'hffff4000, 32'h00018000, 32'h00008000);
        1: begin
          tx_idle_pct = 45;
          rx_idle_pct = 26;
          set_scales(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          set_scales(32'h00000001, 32'h00010000, 32'h00000000);
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 10) random_row();
      send_element(CMD_END, '0, '0);
      wait_drained();
    end
    elem_ch.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d elements in %0d rows, %0d results checked", items_sent,
             rows_ended, results_seen);
    $display("three idle patterns, scale and threshold extremes, table overflow");
    if (mismatches == 0 && orphans == 0 && expected_rows.size() == 0) begin
      $display("sparse_row_scaled_add test passed");
    end else begin
      $display("sparse_row_scaled_add test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
